/* src/jsu_pkg.sv */
// Shared types and constants of the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

  localparam int MaxCapacity = 64;
  localparam int CapRegW = 7;
  localparam logic [CapRegW-1:0] OutCapacityReset = 7'd63;
  localparam int QueueDepth = 2;
  localparam int BurstMax = 4;

  // Register indexes of the configuration port.
  localparam logic RegOutCapacity = 1'b0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       stopped_full;
    logic       last_of_run;
  } out_t;

  // All results caused by one accepted input byte.
  typedef struct packed {
    logic [BurstMax-1:0][7:0] bytes;
    logic [1:0]               count_m1;
    logic                     has_bytes;
    logic                     last;
    logic                     full;
  } burst_t;

endpackage
`default_nettype wire

/* src/jsu_front.sv */
// Front end: decodes escapes, tracks capacity and builds at most one burst per input byte.
`timescale 1ns / 1ps
`default_nettype none
module jsu_front #(
  parameter int MAX_CAPACITY = jsu_pkg::MaxCapacity
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [jsu_pkg::CapRegW-1:0]  out_capacity_i,
  input  wire logic                         accept_i,
  input  wire jsu_pkg::in_t                 in_data_i,
  output logic                              burst_push_o,
  output jsu_pkg::burst_t                   burst_o
);

  localparam int CntW = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
  localparam int CapLog = $clog2(MAX_CAPACITY + 1);
  localparam int CapW = (CapLog > jsu_pkg::CapRegW) ? CapLog : jsu_pkg::CapRegW;
  localparam int CmpW = CapW + 1;

  localparam logic [1:0] ModeNormal = 2'd0;
  localparam logic [1:0] ModeEsc    = 2'd1;
  localparam logic [1:0] ModeHex    = 2'd2;

  localparam logic [7:0] CharBackslash = 8'h5c;
  localparam logic [7:0] CharN = 8'h6e;
  localparam logic [7:0] CharT = 8'h74;
  localparam logic [7:0] CharR = 8'h72;
  localparam logic [7:0] CharB = 8'h62;
  localparam logic [7:0] CharF = 8'h66;
  localparam logic [7:0] CharU = 8'h75;

  localparam logic [7:0]  Utf8Lead2 = 8'hc0;
  localparam logic [7:0]  Utf8Lead3 = 8'he0;
  localparam logic [7:0]  Utf8Cont  = 8'h80;
  localparam logic [15:0] Utf8OneLimit = 16'h0080;
  localparam logic [15:0] Utf8TwoLimit = 16'h0800;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  logic [1:0]      mode_q, mode_d;
  logic [1:0]      hcnt_q, hcnt_d;
  logic [15:0]     cp_q, cp_d;
  logic [7:0]      held_q [3];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full_q, full_d;

  logic [1:0]      dec_mode, dec_hcnt;
  logic [15:0]     dec_cp;
  logic [7:0]      cand [jsu_pkg::BurstMax];
  logic [2:0]      k;
  logic            uni_full, held_we;

  logic [7:0]      b;
  logic            last, is_bs, hex_ok;
  logic [3:0]      hex_v;
  logic [15:0]     cp_next;

  logic [CmpW-1:0] cap_ext, max_ext, cap, cnt_ext, room;
  logic            pre_full, process, take_all, full_after;
  logic [2:0]      n, n_eff;

  assign b       = in_data_i.in_byte;
  assign last    = in_data_i.last_of_string;
  assign is_bs   = (b == CharBackslash);
  assign {hex_ok, hex_v} = hex_value(b);
  assign cp_next = {cp_q[11:0], hex_v};

  assign cap_ext  = CmpW'(out_capacity_i);
  assign max_ext  = CmpW'(MAX_CAPACITY);
  assign cap      = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign cnt_ext  = CmpW'(cnt_q);
  assign pre_full = full_q || !((cnt_ext + CmpW'(1)) < cap);
  assign room     = cap - cnt_ext - CmpW'(1);
  assign process  = accept_i && !pre_full;

  always_comb begin
    dec_mode = mode_q;
    dec_hcnt = hcnt_q;
    dec_cp   = cp_q;
    k        = 3'd0;
    uni_full = 1'b0;
    held_we  = 1'b0;
    for (int i = 0; i < jsu_pkg::BurstMax; i++) begin
      cand[i] = b;
    end
    case (mode_q)
      ModeEsc: begin
        dec_mode = ModeNormal;
        k = 3'd1;
        case (b)
          CharN: cand[0] = 8'h0a;
          CharT: cand[0] = 8'h09;
          CharR: cand[0] = 8'h0d;
          CharB: cand[0] = 8'h08;
          CharF: cand[0] = 8'h0c;
          CharU: begin
            k = 3'd0;
            if (!last) begin
              dec_mode = ModeHex;
              dec_hcnt = 2'd0;
              dec_cp   = 16'd0;
            end
          end
          default: cand[0] = b;
        endcase
      end
      ModeHex: begin
        if (hex_ok && hcnt_q == 2'd3) begin
          dec_cp   = cp_next;
          dec_mode = ModeNormal;
          dec_hcnt = 2'd0;
          if ((cnt_ext + CmpW'(4)) >= cap) begin
            uni_full = 1'b1;
          end else if (cp_next < Utf8OneLimit) begin
            k = 3'd1;
            cand[0] = cp_next[7:0];
          end else if (cp_next < Utf8TwoLimit) begin
            k = 3'd2;
            cand[0] = Utf8Lead2 | {3'b000, cp_next[10:6]};
            cand[1] = Utf8Cont | {2'b00, cp_next[5:0]};
          end else begin
            k = 3'd3;
            cand[0] = Utf8Lead3 | {4'b0000, cp_next[15:12]};
            cand[1] = Utf8Cont | {2'b00, cp_next[11:6]};
            cand[2] = Utf8Cont | {2'b00, cp_next[5:0]};
          end
        end else if (hex_ok && !last) begin
          held_we  = 1'b1;
          dec_cp   = cp_next;
          dec_hcnt = hcnt_q + 2'd1;
        end else begin
          // Abandoned escape: the held digits go out as plain bytes, then this byte unless it is a backslash.
          dec_mode = ModeNormal;
          dec_hcnt = 2'd0;
          for (int i = 0; i < 3; i++) begin
            cand[i] = (2'(i) == hcnt_q) ? b : held_q[i];
          end
          cand[3] = b;
          k = {1'b0, hcnt_q} + {2'b00, !is_bs};
          if (is_bs && !last) begin
            dec_mode = ModeEsc;
          end
        end
      end
      default: begin
        if (is_bs) begin
          if (!last) begin
            dec_mode = ModeEsc;
          end
        end else begin
          k = 3'd1;
          cand[0] = b;
        end
      end
    endcase
  end

  // Only as many bytes as the remaining room allows; running into the limit sets full.
  assign take_all   = CmpW'(k) < room;
  assign n          = take_all ? k : 3'(room);
  assign n_eff      = process ? n : 3'd0;
  assign full_after = pre_full || uni_full || !take_all;

  always_comb begin
    mode_d = mode_q;
    hcnt_d = hcnt_q;
    cp_d   = cp_q;
    cnt_d  = cnt_q;
    full_d = full_q;
    if (accept_i) begin
      full_d = full_after;
      if (process) begin
        mode_d = dec_mode;
        hcnt_d = dec_hcnt;
        cp_d   = dec_cp;
        cnt_d  = cnt_q + CntW'(n_eff);
      end
      if (last) begin
        mode_d = ModeNormal;
        hcnt_d = 2'd0;
        cp_d   = 16'd0;
        cnt_d  = '0;
        full_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      hcnt_q <= 2'd0;
      cp_q   <= 16'd0;
      cnt_q  <= '0;
      full_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      hcnt_q <= hcnt_d;
      cp_q   <= cp_d;
      cnt_q  <= cnt_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && held_we) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) == hcnt_q) begin
          held_q[i] <= b;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < jsu_pkg::BurstMax; i++) begin
      burst_o.bytes[i] = cand[i];
    end
    burst_o.count_m1  = (n_eff == 3'd0) ? 2'd0 : 2'(n_eff - 3'd1);
    burst_o.has_bytes = (n_eff != 3'd0);
    burst_o.last      = last;
    burst_o.full      = full_after;
  end

  assign burst_push_o = accept_i && ((n_eff != 3'd0) || last);

endmodule
`default_nettype wire

/* src/jsu_fifo.sv */
// Short queue of bursts between the decoder front end and the output back end.
`timescale 1ns / 1ps
`default_nettype none
module jsu_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire jsu_pkg::burst_t  data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output jsu_pkg::burst_t       data_o
);

  localparam int Depth = jsu_pkg::QueueDepth;
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  jsu_pkg::burst_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

/* src/jsu_back.sv */
// Back end: hands out the bytes of the head burst one transfer at a time.
`timescale 1ns / 1ps
`default_nettype none
module jsu_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire jsu_pkg::burst_t  burst_i,
  input  wire logic             burst_empty_i,
  output logic                  burst_pop_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output jsu_pkg::out_t         out_data_o
);

  logic [1:0] idx_q, idx_d;
  logic       final_one, take;

  assign empty_o   = burst_empty_i;
  assign take      = pop_i && !burst_empty_i;
  assign final_one = (idx_q == burst_i.count_m1);

  always_comb begin
    out_data_o.out_byte      = burst_i.has_bytes ? burst_i.bytes[idx_q] : 8'd0;
    out_data_o.byte_valid    = burst_i.has_bytes;
    out_data_o.end_of_string = burst_i.last && final_one;
    out_data_o.stopped_full  = burst_i.full;
    out_data_o.last_of_run   = final_one;
  end

  assign burst_pop_o = take && final_one;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = final_one ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

/* src/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper with UTF-8 output.
//
// Input queue side: raw string bytes arrive on in_data_i with last_of_string set
// on the final byte; a transfer happens when push is high and full is low.
// Result queue side: while empty is low the oldest result sits on out_data_o and
// a transfer happens when pop is high. One input byte causes zero to four
// results; a string's last byte always causes at least one, marked end_of_string.
// The results of an input byte are registered in the burst queue before they reach out_data_o.
// Throughput: one input byte per cycle while full is low, and one result per
// cycle out while pop is high, each result its own transfer. A two-entry burst
// queue between decoder and output lets input continue while results wait, so
// full rises only once two bursts are pending behind a stalled receiver.
// The APB port holds out_capacity at address 0; write it only while idle.
// Reset clears the decoder state and the queue and sets out_capacity to 63.
`timescale 1ns / 1ps
`default_nettype none
module json_string_unescape_utf8 #(
  parameter int MAX_CAPACITY = jsu_pkg::MaxCapacity
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire jsu_pkg::in_t  in_data_i,
  output logic               empty,
  input  wire logic          pop,
  output jsu_pkg::out_t      out_data_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [jsu_pkg::CapRegW-1:0] cap_q, cap_d;
  logic                        accept, burst_push, burst_pop, burst_empty;
  jsu_pkg::burst_t             burst_in, burst_head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == jsu_pkg::RegOutCapacity) ? 32'(cap_q) : 32'd0;

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && pready && paddr[2] == jsu_pkg::RegOutCapacity) begin
      cap_d = pwdata[jsu_pkg::CapRegW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= jsu_pkg::OutCapacityReset;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign accept = push && !full;

  jsu_front #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .out_capacity_i(cap_q),
    .accept_i      (accept),
    .in_data_i     (in_data_i),
    .burst_push_o  (burst_push),
    .burst_o       (burst_in)
  );

  jsu_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (burst_push),
    .data_i (burst_in),
    .full_o (full),
    .pop_i  (burst_pop),
    .empty_o(burst_empty),
    .data_o (burst_head)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .burst_i      (burst_head),
    .burst_empty_i(burst_empty),
    .burst_pop_o  (burst_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire
